// ----- rtl/core/pbc_pkg.sv -----
package pbc_pkg;

  // Quality FIFO geometry
  localparam int QUAL_DEPTH = 256;
  localparam int QUAL_AW    = $clog2(QUAL_DEPTH);
  localparam int QUAL_LW    = $clog2(QUAL_DEPTH + 1);

  // Base counters
  localparam int COUNT_BITS = 16;
  localparam int NUM_COUNTS = 8;
  localparam int FIELD_W    = 16;

  // Indel length
  localparam int          SKIP_W   = 16;
  localparam int          PROD_W   = SKIP_W + 4;
  localparam logic [PROD_W-1:0] SKIP_MAX = PROD_W'(16'hFFFF);

  // APB
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_QUAL_LIMIT  = 2'd0;
  localparam logic [1:0] REG_DROP_ENDS   = 2'd1;
  localparam logic [1:0] REG_DROP_STARTS = 2'd2;

  // Last counted base: 0..7 base code, none otherwise
  localparam logic [3:0] LAST_NONE = 4'd15;

  // Characters
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_QUAL   = 2'd1,
    REQ_PILEUP = 2'd2,
    REQ_END    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    MODE_NORMAL      = 3'd0,
    MODE_MAPQ        = 3'd1,
    MODE_AFTER_START = 3'd2,
    MODE_DROP_MAPQ   = 3'd3,
    MODE_DROP_BASE   = 3'd4,
    MODE_DIGITS      = 3'd5,
    MODE_SKIP        = 3'd6
  } mode_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] head;
  } fifo_stat_t;

  // A/C/G/T -> 0..3, a/c/g/t -> 4..7, anything else -> LAST_NONE
  function automatic logic [3:0] base_code(input logic [7:0] c);
    logic [3:0] code;
    code = LAST_NONE;
    unique case (c)
      8'h41:   code = 4'd0;
      8'h43:   code = 4'd1;
      8'h47:   code = 4'd2;
      8'h54:   code = 4'd3;
      8'h61:   code = 4'd4;
      8'h63:   code = 4'd5;
      8'h67:   code = 4'd6;
      8'h74:   code = 4'd7;
      default: code = LAST_NONE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/pileup_base_counter_unit.sv -----
// Channel  | handshake                    | payload
// ---------+------------------------------+--------------------------------------
// in       | in_valid / in_stall          | req_type, byte_value
// out      | out_valid / out_stall        | a..t_count, a..t_forward,
//          |                              | quality_underflow
// cfg      | APB psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
// One input transfer per cycle sustained while in_stall is low. An item is
// captured in the input register, handled against the parse state once it is
// not held, and an end-column item then lands in the result register that
// drives out_valid. The quality FIFO is a 256-byte memory with a registered
// head word, so a pop in every cycle is served.
// Reset (rst, synchronous) clears control state and config; no clearing pass.
// in_stall rises only while an end-column item waits behind a stalled result.
module pileup_base_counter_unit
  import pbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        byte_value,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [FIELD_W-1:0] a_count,
  output logic [FIELD_W-1:0] c_count,
  output logic [FIELD_W-1:0] g_count,
  output logic [FIELD_W-1:0] t_count,
  output logic [FIELD_W-1:0] a_forward,
  output logic [FIELD_W-1:0] c_forward,
  output logic [FIELD_W-1:0] g_forward,
  output logic [FIELD_W-1:0] t_forward,
  output logic              quality_underflow
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0] quality_limit;
  logic       drop_read_ends;
  logic       drop_read_starts;
  logic       cfg_write;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_limit    <= '0;
      drop_read_ends   <= 1'b0;
      drop_read_starts <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_QUAL_LIMIT:  quality_limit    <= pwdata[7:0];
        REG_DROP_ENDS:   drop_read_ends   <= pwdata[0];
        REG_DROP_STARTS: drop_read_starts <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_QUAL_LIMIT:  prdata = APB_DW'(quality_limit);
      REG_DROP_ENDS:   prdata = APB_DW'(drop_read_ends);
      REG_DROP_STARTS: prdata = APB_DW'(drop_read_starts);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       s1_valid;
  req_t       s1_type;
  logic [7:0] s1_byte;
  logic       s1_hold;
  logic       in_accept;
  logic       proc;

  // an end-column item cannot move while the previous result is still stalled
  assign s1_hold   = (s1_type == REQ_END) && out_valid && out_stall;
  assign in_stall  = s1_valid && s1_hold;
  assign in_accept = in_valid && !in_stall;
  assign proc      = s1_valid && !s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && s1_hold);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_type <= req_t'(req_type);
      s1_byte <= byte_value;
    end
  end

  // ---------------------------------------------------------------------
  // Column state
  // ---------------------------------------------------------------------
  mode_t             mode;
  mode_t             mode_next;
  logic [SKIP_W-1:0] skip_length;
  logic [SKIP_W-1:0] skip_next;
  logic [3:0]        last_counted;
  logic [3:0]        last_next;
  logic [7:0]        reference_base;
  logic              underflow_flag;
  logic [COUNT_BITS-1:0] counts [NUM_COUNTS];

  logic do_start;
  logic do_pileup;
  logic do_end;

  assign do_start  = proc && (s1_type == REQ_START);
  assign do_pileup = proc && (s1_type == REQ_PILEUP);
  assign do_end    = proc && (s1_type == REQ_END);

  // FIFO
  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;

  pbc_qual_fifo u_qual_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fifo_ctrl),
    .stat (fifo_stat)
  );

  // ---------------------------------------------------------------------
  // Parser: per-mode decode
  // ---------------------------------------------------------------------
  logic       char_en;      // byte goes through the character rules
  logic       allow_start;  // '^' opens a read start here
  logic       drop_pop;     // skipped read-start base still pops a quality
  logic       is_digit;
  logic [3:0] digit;

  assign is_digit = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);
  assign digit    = 4'(s1_byte - CH_ZERO);

  always_comb begin
    char_en     = 1'b0;
    allow_start = 1'b1;
    drop_pop    = 1'b0;
    unique case (mode)
      MODE_MAPQ,
      MODE_DROP_MAPQ,
      MODE_SKIP: ;
      MODE_AFTER_START: begin
        char_en     = 1'b1;
        allow_start = 1'b0;
      end
      MODE_DROP_BASE: drop_pop = 1'b1;
      MODE_DIGITS:    char_en  = !is_digit && (skip_length == '0);
      default:        char_en  = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------
  // Character rules
  // ---------------------------------------------------------------------
  logic [7:0] mapped;
  logic [3:0] code;
  logic [7:0] qual;
  logic       qual_ok;
  logic       hit_caret;
  logic       hit_base;
  logic       hit_dollar;
  logic       hit_gap;      // '*', 'N', 'n'
  logic       hit_indel;
  logic       pop_req;

  always_comb begin
    mapped = s1_byte;
    if (s1_byte == CH_DOT) begin
      mapped = reference_base;
    end else if (s1_byte == CH_COMMA) begin
      if ((reference_base >= CH_UPPER_A) && (reference_base <= CH_UPPER_Z)) begin
        mapped = reference_base + CASE_OFFSET;
      end else begin
        mapped = reference_base;
      end
    end
  end

  assign code    = base_code(mapped);
  assign qual    = fifo_stat.empty ? 8'd0 : fifo_stat.head;
  assign qual_ok = (qual >= quality_limit);

  // raw '^' is checked before the reference mapping; it is never a base
  assign hit_caret  = char_en && (s1_byte == CH_CARET);
  assign hit_base   = char_en && (code != LAST_NONE);
  assign hit_dollar = char_en && (mapped == CH_DOLLAR);
  assign hit_gap    = char_en && ((mapped == CH_STAR) || (mapped == CH_UPPER_N) ||
                                  (mapped == CH_LOWER_N));
  assign hit_indel  = char_en && ((mapped == CH_PLUS) || (mapped == CH_MINUS));

  assign pop_req = do_pileup && (drop_pop || hit_base || hit_gap);

  assign fifo_ctrl.push  = proc && (s1_type == REQ_QUAL);
  assign fifo_ctrl.pop   = pop_req;
  assign fifo_ctrl.wdata = s1_byte;

  // ---------------------------------------------------------------------
  // Next mode
  // ---------------------------------------------------------------------
  logic [SKIP_W-1:0] skip_dec;
  logic [PROD_W-1:0] skip_prod;

  assign skip_dec  = skip_length - SKIP_W'(1);
  assign skip_prod = PROD_W'({skip_length, 3'b000}) + PROD_W'({skip_length, 1'b0}) +
                     PROD_W'(digit);

  always_comb begin
    mode_next = mode;
    if (do_start) begin
      mode_next = MODE_NORMAL;
    end else if (do_pileup) begin
      unique case (mode)
        MODE_MAPQ:        mode_next = MODE_AFTER_START;
        MODE_DROP_MAPQ:   mode_next = MODE_DROP_BASE;
        MODE_AFTER_START,
        MODE_DROP_BASE:   mode_next = MODE_NORMAL;
        MODE_DIGITS: begin
          if (is_digit) begin
            mode_next = MODE_DIGITS;
          end else if (skip_length == '0) begin
            mode_next = MODE_NORMAL;
          end else begin
            mode_next = (skip_dec != '0) ? MODE_SKIP : MODE_NORMAL;
          end
        end
        MODE_SKIP: begin
          if ((skip_length == '0) || (skip_dec == '0)) begin
            mode_next = MODE_NORMAL;
          end
        end
        default: mode_next = MODE_NORMAL;
      endcase
      // character rules land after the mode step
      priority if (hit_caret && allow_start) begin
        mode_next = drop_read_starts ? MODE_DROP_MAPQ : MODE_MAPQ;
      end else if (hit_indel) begin
        mode_next = MODE_DIGITS;
      end else begin
      end
    end
  end

  // ---------------------------------------------------------------------
  // Skip length
  // ---------------------------------------------------------------------
  always_comb begin
    skip_next = skip_length;
    if (do_start) begin
      skip_next = '0;
    end else if (do_pileup) begin
      if (hit_indel) begin
        skip_next = '0;
      end else if (mode == MODE_DIGITS) begin
        if (is_digit) begin
          skip_next = (skip_prod > SKIP_MAX) ? SKIP_W'(SKIP_MAX) : SKIP_W'(skip_prod);
        end else if (skip_length != '0) begin
          skip_next = skip_dec;
        end
      end else if ((mode == MODE_SKIP) && (skip_length != '0)) begin
        skip_next = skip_dec;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Counter steps and last counted base
  // ---------------------------------------------------------------------
  logic [NUM_COUNTS-1:0] inc_vec;
  logic [NUM_COUNTS-1:0] dec_vec;

  always_comb begin
    inc_vec   = '0;
    dec_vec   = '0;
    last_next = last_counted;
    if (do_start) begin
      last_next = LAST_NONE;
    end else if (do_pileup) begin
      if (hit_base) begin
        if (qual_ok) begin
          last_next = code;
          inc_vec[{1'b0, code[1:0]}] = 1'b1;
          if (!code[2]) begin
            inc_vec[{1'b1, code[1:0]}] = 1'b1;
          end
        end else begin
          last_next = LAST_NONE;
        end
      end else if (hit_dollar) begin
        if (drop_read_ends && !last_counted[3]) begin
          dec_vec[{1'b0, last_counted[1:0]}] = 1'b1;
          if (!last_counted[2]) begin
            dec_vec[{1'b1, last_counted[1:0]}] = 1'b1;
          end
        end
        last_next = LAST_NONE;
      end else if (hit_gap) begin
        last_next = LAST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      skip_length    <= '0;
      last_counted   <= LAST_NONE;
      reference_base <= '0;
      underflow_flag <= 1'b0;
    end else begin
      mode         <= mode_next;
      skip_length  <= skip_next;
      last_counted <= last_next;
      if (do_start) begin
        reference_base <= s1_byte;
        underflow_flag <= 1'b0;
      end else if (pop_req && fifo_stat.empty) begin
        underflow_flag <= 1'b1;
      end
    end
  end

  // saturating at both ends
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COUNTS; i++) begin
        if (do_start) begin
          counts[i] <= '0;
        end else if (inc_vec[i] && (counts[i] != '1)) begin
          counts[i] <= counts[i] + COUNT_BITS'(1);
        end else if (dec_vec[i] && (counts[i] != '0)) begin
          counts[i] <= counts[i] - COUNT_BITS'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [FIELD_W-1:0] res_counts [NUM_COUNTS];
  logic               res_underflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= do_end || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (do_end) begin
      for (int i = 0; i < NUM_COUNTS; i++) begin
        res_counts[i] <= FIELD_W'(counts[i]);
      end
      res_underflow <= underflow_flag;
    end
  end

  assign a_count           = res_counts[0];
  assign c_count           = res_counts[1];
  assign g_count           = res_counts[2];
  assign t_count           = res_counts[3];
  assign a_forward         = res_counts[4];
  assign c_forward         = res_counts[5];
  assign g_forward         = res_counts[6];
  assign t_forward         = res_counts[7];
  assign quality_underflow = res_underflow;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && (s1_type == REQ_END)))
    else $error("result raised without an end-column item");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_SKIP) |-> (skip_length != '0))
    else $error("skip mode with zero skip length");

  a_underflow_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(underflow_flag) |-> $past(fifo_stat.empty && pop_req))
    else $error("underflow flag set without an empty pop");

endmodule

// ----- rtl/core/pbc_qual_fifo.sv -----
module pbc_qual_fifo
  import pbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctrl_t ctrl,
  output fifo_stat_t stat
);

  logic [7:0]         mem [QUAL_DEPTH];
  logic [QUAL_AW-1:0] rptr;
  logic [QUAL_AW-1:0] wptr;
  logic [QUAL_LW-1:0] level;
  logic [7:0]         rd_data;

  logic               push_ok;
  logic               pop_ok;
  logic [QUAL_AW-1:0] rptr_inc;
  logic [QUAL_AW-1:0] wptr_inc;
  logic [QUAL_AW-1:0] rd_addr;
  logic [QUAL_LW-1:0] level_next;

  assign push_ok = ctrl.push && (level != QUAL_LW'(QUAL_DEPTH));
  assign pop_ok  = ctrl.pop && (level != '0);

  assign rptr_inc = (rptr == QUAL_AW'(QUAL_DEPTH - 1)) ? '0 : rptr + QUAL_AW'(1);
  assign wptr_inc = (wptr == QUAL_AW'(QUAL_DEPTH - 1)) ? '0 : wptr + QUAL_AW'(1);

  // head register tracks the entry at the read pointer (first-word fall-through)
  assign rd_addr = pop_ok ? rptr_inc : rptr;

  always_comb begin
    level_next = level;
    if (push_ok && !pop_ok) begin
      level_next = level + QUAL_LW'(1);
    end else if (pop_ok && !push_ok) begin
      level_next = level - QUAL_LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      level <= '0;
    end else begin
      level <= level_next;
      if (push_ok) begin
        wptr <= wptr_inc;
      end
      if (pop_ok) begin
        rptr <= rptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr] <= ctrl.wdata;
    end
  end

  // write-through when the entry being read is written in the same cycle
  always_ff @(posedge clk) begin
    if (push_ok && (wptr == rd_addr)) begin
      rd_data <= ctrl.wdata;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

  assign stat.empty = (level == '0);
  assign stat.head  = rd_data;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QUAL_LW'(QUAL_DEPTH))
    else $error("quality FIFO level beyond depth");

  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    (pop_ok && !push_ok) |=> (level == $past(level) - QUAL_LW'(1)))
    else $error("quality FIFO level not decremented on pop");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((level == '0) || (level == QUAL_LW'(QUAL_DEPTH))) |-> (rptr == wptr))
    else $error("quality FIFO pointers disagree with level");

endmodule
